>>> rtl/siru_pkg.sv
// shared types, register map and keys of the software interrupt request unit
package siru_pkg;

	localparam int NUM_REQ = 4;
	localparam int IDX_W = $clog2(NUM_REQ);

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [7:0] OFS_REQ_FIRST = 8'hB0;
	localparam logic [7:0] OFS_REQ_LAST = 8'hBC;
	localparam logic [7:0] OFS_EXC_STAT = 8'hE0;
	localparam logic [7:0] OFS_VECTOR = 8'hF4;
	localparam logic [7:0] OFS_FLAGS = 8'hF8;

	// bits 15:8 of a request write must match the key of its register
	localparam logic [7:0] REQ_KEY [NUM_REQ] = '{8'h75, 8'h84, 8'h93, 8'hA2};

	localparam int EXC_RST_SET_BIT = 15;
	localparam int EXC_RST_CLR_BIT = 14;

	typedef struct packed {
		logic capture;
		logic execute;
	} siru_cmd_t;

endpackage

>>> rtl/siru_ctrl.sv
// controller: input/execute sequencing and output register handshake
module siru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output siru_pkg::siru_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.execute = (state_q == ST_EXEC) && out_free;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// wait here while an unread result blocks the output register
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/siru_dp.sv
// datapath: request bytes, pending flags, vector encode and result register
module siru_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  siru_pkg::siru_cmd_t cmd,
	input  logic                in_kind,
	input  logic [7:0]          in_byte_offset,
	input  logic [31:0]         in_write_data,
	output logic [31:0]         read_data,
	output logic                irq_level,
	output logic                reset_request
);

	logic                          kind_q;
	logic [7:0]                    ofs_q;
	logic [31:0]                   wdata_q;
	logic [7:0]                    req_data_q [siru_pkg::NUM_REQ];
	logic [siru_pkg::NUM_REQ-1:0]  pend_q;
	logic [31:0]                   rd_q;
	logic                          irq_q;
	logic                          rst_q;

	logic [siru_pkg::IDX_W-1:0]    n;
	logic [siru_pkg::NUM_REQ-1:0]  n_hot;
	logic [siru_pkg::NUM_REQ-1:0]  low_hot;
	logic [7:0]                    n_data;
	logic [7:0]                    vec_data;
	logic [7:0]                    vec_num;
	logic [15:0]                   vec;
	logic [siru_pkg::NUM_REQ-1:0]  pend_d;
	logic                          req_wr;
	logic [31:0]                   rd_d;
	logic                          rst_d;

	assign n = ofs_q[siru_pkg::IDX_W+1:2];
	assign n_hot = siru_pkg::NUM_REQ'(1) << n;
	// lowest pending request, one-hot
	assign low_hot = pend_q & (~pend_q + siru_pkg::NUM_REQ'(1));

	always_comb begin
		n_data = '0;
		vec_data = '0;
		vec_num = '0;
		for (int i = 0; i < siru_pkg::NUM_REQ; i++) begin
			n_data = n_data | (req_data_q[i] & {8{n_hot[i]}});
			vec_data = vec_data | (req_data_q[i] & {8{low_hot[i]}});
			vec_num = vec_num | (8'(i + 1) & {8{low_hot[i]}});
		end
		vec = {vec_data, vec_num};
	end

	always_comb begin
		pend_d = pend_q;
		rd_d = '0;
		rst_d = 1'b0;
		req_wr = 1'b0;
		if (kind_q == siru_pkg::KIND_WRITE) begin
			unique case (ofs_q) inside
				[siru_pkg::OFS_REQ_FIRST:siru_pkg::OFS_REQ_LAST]: begin
					if (wdata_q[15:8] == siru_pkg::REQ_KEY[n]) begin
						req_wr = 1'b1;
						pend_d = pend_q | n_hot;
					end
				end
				siru_pkg::OFS_EXC_STAT: begin
					rst_d = wdata_q[siru_pkg::EXC_RST_SET_BIT]
						|| !wdata_q[siru_pkg::EXC_RST_CLR_BIT];
				end
				siru_pkg::OFS_FLAGS: begin
					pend_d = pend_q & ~wdata_q[siru_pkg::NUM_REQ-1:0];
				end
				default: ;
			endcase
		end else begin
			unique case (ofs_q) inside
				[siru_pkg::OFS_REQ_FIRST:siru_pkg::OFS_REQ_LAST]: begin
					rd_d = {24'b0, n_data};
				end
				siru_pkg::OFS_VECTOR: begin
					rd_d = {16'b0, vec};
					// drop the lowest pending flag; nothing changes when none pending
					pend_d = pend_q & (pend_q - siru_pkg::NUM_REQ'(1));
				end
				siru_pkg::OFS_FLAGS: begin
					rd_d = {{(32 - siru_pkg::NUM_REQ){1'b0}}, pend_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			ofs_q <= in_byte_offset;
			wdata_q <= in_write_data;
		end
		if (cmd.execute) begin
			rd_q <= rd_d;
			irq_q <= |pend_d;
			rst_q <= rst_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			for (int i = 0; i < siru_pkg::NUM_REQ; i++) begin
				req_data_q[i] <= '0;
			end
		end else if (cmd.execute) begin
			pend_q <= pend_d;
			if (req_wr) begin
				req_data_q[n] <= wdata_q[7:0];
			end
		end
	end

	assign read_data = rd_q;
	assign irq_level = irq_q;
	assign reset_request = rst_q;

endmodule

>>> rtl/software_interrupt_request_unit.sv
// top level of the software interrupt request unit
// Each register access is first captured and then executed against the request bytes
// and pending flags by the capture/execute sequence of the controller, which takes no
// new transaction until the last one has executed. Results sit in an output register,
// so the next transaction is taken while a result waits; execution holds only when that
// register is still full. Request registers live at 0xB0..0xBC (key in bits 15:8),
// exception status at 0xE0, the vector at 0xF4 and the flag register at 0xF8. irq_level
// and reset_request are reported with each result, as they stand after that access.
module software_interrupt_request_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // byte_offset[7:0], write_data[39:8]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // read_data[31:0], irq_level[32], reset_request[33], zero
);

	siru_pkg::siru_cmd_t cmd;
	logic [31:0]         read_data;
	logic                irq_level;
	logic                reset_request;

	siru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	siru_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_kind        (s_tuser),
		.in_byte_offset (s_tdata[7:0]),
		.in_write_data  (s_tdata[39:8]),
		.read_data      (read_data),
		.irq_level      (irq_level),
		.reset_request  (reset_request)
	);

	assign m_tdata = {6'b0, reset_request, irq_level, read_data};

endmodule

>>> rtl/siru_chk.sv
// port checker for the software interrupt request unit, bound to the top level
module siru_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// one transaction in flight on the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two consecutive cycles");

	// a reset request comes only from a write, which returns no read data
	a_rst_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tdata[31:0] == 32'b0)
		else $error("reset request with nonzero read data");

	// pad bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'b0)
		else $error("result pad bits not zero");

	// a stalled result is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

endmodule

bind software_interrupt_request_unit siru_chk u_siru_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> verif/software_interrupt_request_unit_tb.sv
// testbench for the software interrupt request unit: directed and random register traffic
`timescale 1ns / 1ps

module software_interrupt_request_unit_tb;

	localparam int MAX_GAP = 8;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        reset_request;
	} access_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // byte_offset[7:0], write_data[39:8]
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // read_data[31:0], irq_level[32], reset_request[33], zero

	// shadow copy of the block state
	logic [7:0]  shadow_req_data [siru_pkg::NUM_REQ];
	logic [3:0]  shadow_pending;
	logic [15:0] shadow_vector;

	access_result_t awaited_results [$];
	int          error_count;
	int          quiet_cycles;
	bit          no_idle;

	software_interrupt_request_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// vector of the lowest pending request, zero when none is pending
	function automatic logic [15:0] lowest_vector(input logic [3:0] flags);
		logic [15:0] vec;
		vec = '0;
		for (int n = siru_pkg::NUM_REQ - 1; n >= 0; n--) begin
			if (flags[n])
				vec = {shadow_req_data[n], 8'h00} + 16'(n + 1);
		end
		return vec;
	endfunction

	task automatic predict_access(input logic kind, input logic [7:0] ofs,
			input logic [31:0] wdata);
		access_result_t res;
		logic [7:0]     rel;
		logic [1:0]     idx;
		res = '0;
		rel = ofs - siru_pkg::OFS_REQ_FIRST;
		idx = rel[3:2];
		if (kind == siru_pkg::KIND_WRITE) begin
			if (ofs >= siru_pkg::OFS_REQ_FIRST && ofs <= siru_pkg::OFS_REQ_LAST) begin
				if (wdata[15:8] == siru_pkg::REQ_KEY[idx]) begin
					shadow_req_data[idx] = wdata[7:0];
					shadow_pending[idx] = 1'b1;
					shadow_vector = lowest_vector(shadow_pending);
				end
			end else if (ofs == siru_pkg::OFS_EXC_STAT) begin
				res.reset_request = wdata[siru_pkg::EXC_RST_SET_BIT]
					|| !wdata[siru_pkg::EXC_RST_CLR_BIT];
			end else if (ofs == siru_pkg::OFS_FLAGS) begin
				shadow_pending = shadow_pending & ~wdata[3:0];
				shadow_vector = lowest_vector(shadow_pending);
			end
		end else begin
			if (ofs >= siru_pkg::OFS_REQ_FIRST && ofs <= siru_pkg::OFS_REQ_LAST) begin
				res.read_data = {24'h0, shadow_req_data[idx]};
			end else if (ofs == siru_pkg::OFS_VECTOR) begin
				res.read_data = {16'h0, shadow_vector};
				// a read of an empty vector must leave the flags alone
				if (shadow_vector != 16'h0) begin
					idx = 2'(shadow_vector[7:0] - 8'd1);
					shadow_pending[idx] = 1'b0;
					shadow_vector = lowest_vector(shadow_pending);
				end
			end else if (ofs == siru_pkg::OFS_FLAGS) begin
				res.read_data = {28'h0, shadow_pending};
			end
		end
		res.irq_level = |shadow_pending;
		awaited_results.push_back(res);
	endtask

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_access(input logic kind, input logic [7:0] ofs,
			input logic [31:0] wdata);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {wdata, ofs};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_access(kind, ofs, wdata);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_random_access();
		int          pick;
		int          n;
		logic [31:0] rnd;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, siru_pkg::NUM_REQ - 1);
		rnd = $urandom;
		if (pick < 35)
			send_access(siru_pkg::KIND_WRITE,
				siru_pkg::OFS_REQ_FIRST + 8'(4 * n) + 8'($urandom_range(0, 3)),
				{rnd[31:16], siru_pkg::REQ_KEY[n], rnd[7:0]});
		else if (pick < 43)
			send_access(siru_pkg::KIND_WRITE,
				siru_pkg::OFS_REQ_FIRST + 8'($urandom_range(0, 15)), rnd);
		else if (pick < 60)
			send_access(siru_pkg::KIND_READ, siru_pkg::OFS_VECTOR, rnd);
		else if (pick < 66)
			send_access(siru_pkg::KIND_READ,
				siru_pkg::OFS_REQ_FIRST + 8'($urandom_range(0, 15)), rnd);
		else if (pick < 70)
			send_access(siru_pkg::KIND_READ, siru_pkg::OFS_FLAGS, rnd);
		else if (pick < 78)
			send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_FLAGS, rnd);
		else if (pick < 86)
			send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_EXC_STAT, rnd);
		else
			send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
	endtask

	task automatic test_after_reset();
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_REQ_FIRST, 32'hFFFF_FFFF);
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_VECTOR, 32'h0);
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_FLAGS, 32'h0);
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_EXC_STAT, 32'h0);
	endtask

	task automatic test_request_writes();
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_REQ_FIRST,
			{16'hFFFF, siru_pkg::REQ_KEY[0], 8'hFF});
		// unaligned offset still selects its word
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_REQ_FIRST + 8'd5,
			{16'h0000, siru_pkg::REQ_KEY[1], 8'h00});
		// key of another register is rejected
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_REQ_FIRST + 8'd8,
			{16'h1234, siru_pkg::REQ_KEY[0], 8'h3C});
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_REQ_LAST + 8'd3,
			{16'hA5A5, siru_pkg::REQ_KEY[3], 8'h5A});
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_REQ_LAST, 32'h0);
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_FLAGS, 32'h0);
	endtask

	task automatic test_vector_reads();
		repeat (4)
			send_access(siru_pkg::KIND_READ, siru_pkg::OFS_VECTOR, 32'h0);
	endtask

	task automatic test_flag_register();
		for (int n = 0; n < siru_pkg::NUM_REQ; n++)
			send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_REQ_FIRST + 8'(4 * n),
				{16'h0, siru_pkg::REQ_KEY[n], 8'(8'h11 * n)});
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_FLAGS, 32'hFFFF_FFF0);
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_FLAGS, 32'h0000_0005);
		send_access(siru_pkg::KIND_READ, siru_pkg::OFS_VECTOR, 32'h0);
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_FLAGS, 32'h0000_000F);
	endtask

	task automatic test_exception_status();
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_EXC_STAT, 32'h0000_8000);
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_EXC_STAT, 32'h0000_4000);
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_EXC_STAT, 32'h0000_0000);
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_EXC_STAT, 32'hFFFF_7FFF);
	endtask

	task automatic test_unmapped();
		send_access(siru_pkg::KIND_WRITE, siru_pkg::OFS_VECTOR, 32'hFFFF_FFFF);
		send_access(siru_pkg::KIND_READ, 8'h00, 32'hFFFF_FFFF);
		send_access(siru_pkg::KIND_WRITE, 8'hFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 149)
				wait_results_drained();
			send_random_access();
		end
	endtask

	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		repeat (count)
			send_random_access();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = siru_pkg::KIND_READ;
		s_tdata = '0;
		no_idle = 1'b0;
		error_count = 0;
		for (int n = 0; n < siru_pkg::NUM_REQ; n++)
			shadow_req_data[n] = 8'h00;
		shadow_pending = 4'h0;
		shadow_vector = 16'h0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_after_reset();
		test_request_writes();
		test_vector_reads();
		test_flag_register();
		test_exception_status();
		test_unmapped();
		test_random_traffic(550);
		test_back_to_back(150);

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stall before each transaction, then compare
	initial begin
		access_result_t exp_res;
		int             stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (awaited_results.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				exp_res = awaited_results.pop_front();
				if (m_tdata[31:0] !== exp_res.read_data) begin
					$error("read_data: expected %h, actual %h", exp_res.read_data, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[32] !== exp_res.irq_level) begin
					$error("irq_level: expected %b, actual %b", exp_res.irq_level, m_tdata[32]);
					error_count++;
				end
				if (m_tdata[33] !== exp_res.reset_request) begin
					$error("reset_request: expected %b, actual %b",
						exp_res.reset_request, m_tdata[33]);
					error_count++;
				end
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

>>> sim.f
rtl/siru_pkg.sv
rtl/siru_ctrl.sv
rtl/siru_dp.sv
rtl/software_interrupt_request_unit.sv
rtl/siru_chk.sv
verif/software_interrupt_request_unit_tb.sv
